// ===== rtl/jsu_pkg.sv =====
// Shared types and constants for the JSON string unescape unit.
// Decoder phases, result kinds and the source characters the decoder matches.
// No dependencies.
package jsu_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_BODY   = 3'd1,
		PH_ESC    = 3'd2,
		PH_HEX1   = 3'd3,
		PH_WANTBS = 3'd4,
		PH_WANTU  = 3'd5,
		PH_HEX2   = 3'd6,
		PH_DRAIN  = 3'd7
	} phase_t;

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	localparam int unsigned MAX_RES = 4;
	localparam int unsigned RES_IDX_W = $clog2(MAX_RES);

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [7:0] CTL_BS = 8'h08;
	localparam logic [7:0] CTL_FF = 8'h0C;
	localparam logic [7:0] CTL_LF = 8'h0A;
	localparam logic [7:0] CTL_CR = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;

	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG = 6'b110111;
	localparam logic [10:0] PLANE_OFFSET = 11'h040;

endpackage

// ===== rtl/json_string_unescape_unit.sv =====
// JSON string unescape unit, top level and decoder.
// Depends on jsu_pkg for phases, result kinds and character constants.
//
// An accepted byte is held in the input stage; its results are registered in the
// result stage. Throughput: one source byte per cycle while m_tready is high and
// each byte yields at most one result; a byte that yields n results (up to four,
// from a \u escape) holds the result register, one result per cycle with m_tready.
// Reset: arst_n clears both stages and returns the decoder to idle, state zero.
module json_string_unescape_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_byte
	input  logic       s_tlast,   // end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic [1:0] m_tuser,   // [1:0] out_kind
	output logic       m_tlast    // run_last
);
	import jsu_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eoi_s1;

	// decoder state
	phase_t      phase_q;
	logic [15:0] accum_q;
	logic [1:0]  cnt_q;
	logic [9:0]  high_q;

	// result stage
	logic                 valid_s2;
	logic [7:0]           res_byte_s2 [MAX_RES];
	kind_t                res_kind_s2;
	logic [RES_IDX_W-1:0] res_last_s2;
	logic [RES_IDX_W-1:0] idx_q;

	// shared decode terms
	logic        hex_ok;
	logic [3:0]  digit;
	logic [15:0] accum_sh;
	logic        dig_done;
	logic        is_high;
	logic        is_low;
	logic [10:0] pair_hi;

	always_comb begin
		hex_ok = 1'b1;
		digit = 4'd0;
		if (byte_s1 inside {[8'h30:8'h39]}) begin
			digit = byte_s1[3:0];
		end else if (byte_s1 inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			digit = byte_s1[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
	end

	assign accum_sh = {accum_q[11:0], digit};
	assign dig_done = (cnt_q == 2'd3);
	assign is_high = (accum_sh[15:10] == SURR_HIGH_TAG);
	assign is_low = (accum_sh[15:10] == SURR_LOW_TAG);
	assign pair_hi = {1'b0, high_q} + PLANE_OFFSET;

	// next state of the decoder, before end-of-input and error handling
	phase_t      phase_step;
	logic [15:0] accum_d;
	logic [1:0]  cnt_d;
	logic [9:0]  high_d;

	always_comb begin
		phase_step = phase_q;
		accum_d = accum_q;
		cnt_d = cnt_q;
		high_d = high_q;
		case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == CH_QUOTE) phase_step = PH_BODY;
			end
			PH_BODY: begin
				if (byte_s1 == CH_BSLASH) phase_step = PH_ESC;
			end
			PH_ESC: begin
				phase_step = PH_BODY;
				if (byte_s1 == CH_U) begin
					phase_step = PH_HEX1;
					accum_d = '0;
					cnt_d = '0;
				end
			end
			PH_HEX1, PH_HEX2: begin
				if (hex_ok) begin
					accum_d = accum_sh;
					cnt_d = dig_done ? 2'd0 : cnt_q + 2'd1;
					if (dig_done) begin
						if (phase_q == PH_HEX2) begin
							phase_step = PH_BODY;
						end else if (is_high) begin
							high_d = accum_sh[9:0];
							phase_step = PH_WANTBS;
						end else begin
							phase_step = PH_BODY;
						end
					end
				end
			end
			PH_WANTBS: begin
				if (byte_s1 == CH_BSLASH) phase_step = PH_WANTU;
			end
			PH_WANTU: begin
				if (byte_s1 == CH_U) begin
					phase_step = PH_HEX2;
					accum_d = '0;
					cnt_d = '0;
				end
			end
			default: phase_step = PH_DRAIN;
		endcase
	end

	// results caused by the byte in the input stage
	logic       err_raw;
	logic       closed;
	logic [2:0] nb;
	logic [7:0] buf_b [MAX_RES];

	always_comb begin
		err_raw = 1'b0;
		closed = 1'b0;
		nb = 3'd0;
		for (int i = 0; i < MAX_RES; i++) buf_b[i] = 8'h00;
		case (phase_q)
			PH_IDLE: err_raw = (byte_s1 != CH_QUOTE);
			PH_BODY: begin
				if (byte_s1 == CH_QUOTE) begin
					closed = 1'b1;
				end else if (byte_s1 == CH_BSLASH) begin
					nb = 3'd0;
				end else if (byte_s1 < CH_SPACE) begin
					err_raw = 1'b1;
				end else begin
					nb = 3'd1;
					buf_b[0] = byte_s1;
				end
			end
			PH_ESC: begin
				nb = 3'd1;
				case (byte_s1)
					CH_QUOTE, CH_BSLASH, CH_SLASH: buf_b[0] = byte_s1;
					CH_B: buf_b[0] = CTL_BS;
					CH_F: buf_b[0] = CTL_FF;
					CH_N: buf_b[0] = CTL_LF;
					CH_R: buf_b[0] = CTL_CR;
					CH_T: buf_b[0] = CTL_TAB;
					CH_U: nb = 3'd0;
					default: begin
						nb = 3'd0;
						err_raw = 1'b1;
					end
				endcase
			end
			PH_HEX1: begin
				if (!hex_ok) begin
					err_raw = 1'b1;
				end else if (dig_done && !is_high) begin
					if (accum_sh[15:7] == '0) begin
						nb = 3'd1;
						buf_b[0] = accum_sh[7:0];
					end else if (accum_sh[15:11] == '0) begin
						nb = 3'd2;
						buf_b[0] = {3'b110, accum_sh[10:6]};
						buf_b[1] = {2'b10, accum_sh[5:0]};
					end else begin
						nb = 3'd3;
						buf_b[0] = {4'b1110, accum_sh[15:12]};
						buf_b[1] = {2'b10, accum_sh[11:6]};
						buf_b[2] = {2'b10, accum_sh[5:0]};
					end
				end
			end
			PH_WANTBS: err_raw = (byte_s1 != CH_BSLASH);
			PH_WANTU: err_raw = (byte_s1 != CH_U);
			PH_HEX2: begin
				if (!hex_ok) begin
					err_raw = 1'b1;
				end else if (dig_done) begin
					if (!is_low) begin
						err_raw = 1'b1;
					end else begin
						// code point bits [20:10] are pair_hi, [9:0] the low half
						nb = 3'd4;
						buf_b[0] = {5'b11110, pair_hi[10:8]};
						buf_b[1] = {2'b10, pair_hi[7:2]};
						buf_b[2] = {2'b10, pair_hi[1:0], accum_sh[9:6]};
						buf_b[3] = {2'b10, accum_sh[5:0]};
					end
				end
			end
			default: nb = 3'd0;
		endcase
	end

	logic   err;
	logic   has_res;
	phase_t phase_d;

	// end of input inside an open string is an error; any pending bytes are dropped
	assign err = err_raw || (eoi_s1 && !closed && phase_step != PH_DRAIN);
	assign has_res = err || closed || (nb != 3'd0);

	always_comb begin
		if (err || closed) phase_d = eoi_s1 ? PH_IDLE : PH_DRAIN;
		else phase_d = eoi_s1 ? PH_IDLE : phase_step;
	end

	// handshake
	logic out_done;
	logic s2_load_ok;
	logic s1_adv;

	assign m_tvalid = valid_s2;
	assign m_tlast = (idx_q == res_last_s2);
	assign m_tdata = res_byte_s2[idx_q];
	assign m_tuser = res_kind_s2;
	assign out_done = valid_s2 && m_tready && m_tlast;
	assign s2_load_ok = !valid_s2 || out_done;
	assign s1_adv = valid_s1 && (!has_res || s2_load_ok);
	assign s_tready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eoi_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			accum_q <= '0;
			cnt_q <= '0;
			high_q <= '0;
		end else if (s1_adv) begin
			phase_q <= phase_d;
			accum_q <= accum_d;
			cnt_q <= cnt_d;
			high_q <= high_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else if (s1_adv && has_res) begin
			valid_s2 <= 1'b1;
			idx_q <= '0;
		end else if (out_done) begin
			valid_s2 <= 1'b0;
			idx_q <= '0;
		end else if (valid_s2 && m_tready) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && has_res) begin
			if (err || closed) begin
				for (int i = 0; i < MAX_RES; i++) res_byte_s2[i] <= 8'h00;
				res_kind_s2 <= err ? KIND_ERROR : KIND_CLOSE;
				res_last_s2 <= '0;
			end else begin
				for (int i = 0; i < MAX_RES; i++) res_byte_s2[i] <= buf_b[i];
				res_kind_s2 <= KIND_BYTE;
				res_last_s2 <= RES_IDX_W'(nb - 3'd1);
			end
		end
	end

	// the read pointer never runs past the last filled result
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> idx_q <= res_last_s2)
		else $error("result index past last entry");

	// close and error are always a run of one
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_kind_s2 != KIND_BYTE) |-> (res_last_s2 == '0 && m_tdata == 8'h00))
		else $error("close or error result not a single zero result");

	// the last source byte always leaves the decoder idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && eoi_s1) |=> (phase_q == PH_IDLE))
		else $error("decoder not idle after end of input");

	// a byte is never dropped while results wait to be loaded
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && has_res && valid_s2 && !out_done) |=> valid_s1)
		else $error("input byte lost while result stage busy");

endmodule

// ===== test/tb_json_string_unescape_unit.sv =====
// Self-checking bench for json_string_unescape_unit: directed and random string literals.
// Uses jsu_pkg for phases, result kinds and character constants; drives the reset and the stream ports only.
// Expected decoded bytes come from an in-bench model of the unescaper.
module tb_json_string_unescape_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import jsu_pkg::*;

	localparam int HALF_PERIOD    = 6;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SECTION_BYTES  = 65;
	localparam int DRAIN_CYCLES   = 20;

	localparam logic [7:0] DIG_0 = "0";
	localparam logic [7:0] LOW_A = "a";
	localparam logic [7:0] UP_A  = "A";

	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
	} src_byte_t;

	typedef struct packed {
		logic [7:0] data;
		kind_t      kind;
		logic       last;
	} dec_result_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = '0;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	src_byte_t   src_bytes[$];
	dec_result_t expected_out[$];

	// decoder model state
	phase_t      dec_phase = PH_IDLE;
	logic [15:0] hex_acc = '0;
	logic [1:0]  hex_cnt = '0;
	logic [9:0]  hi_half = '0;

	int snd_idle_pct = 19;
	int rcv_idle_pct = 80;
	bit hold_go = 1'b0;
	int hold_cnt = 0;
	int idle_cycles = 0;
	int fail_count = 0;
	int bytes_queued = 0;
	int strings_queued = 0;
	int bytes_sent = 0;
	int results_seen = 0;
	int closes_seen = 0;
	int errors_seen = 0;

	json_string_unescape_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #(HALF_PERIOD) clk = ~clk;

	function automatic int hex_val(input logic [7:0] b);
		if (b >= "0" && b <= "9") return int'(b - "0");
		if (b >= "a" && b <= "f") return int'(b - "a") + 10;
		if (b >= "A" && b <= "F") return int'(b - "A") + 10;
		return -1;
	endfunction

	function automatic int utf8_encode(input logic [20:0] cp, output logic [3:0][7:0] seq);
		seq = '0;
		if (cp <= 21'h7F) begin
			seq[0] = cp[7:0];
			return 1;
		end
		if (cp <= 21'h7FF) begin
			seq[0] = {3'b110, cp[10:6]};
			seq[1] = {2'b10, cp[5:0]};
			return 2;
		end
		if (cp <= 21'hFFFF) begin
			seq[0] = {4'b1110, cp[15:12]};
			seq[1] = {2'b10, cp[11:6]};
			seq[2] = {2'b10, cp[5:0]};
			return 3;
		end
		seq[0] = {5'b11110, cp[20:18]};
		seq[1] = {2'b10, cp[17:12]};
		seq[2] = {2'b10, cp[11:6]};
		seq[3] = {2'b10, cp[5:0]};
		return 4;
	endfunction

	// Advance the decoder model by one accepted source byte and queue its results.
	task automatic unescape_byte(input logic [7:0] b, input logic eoi);
		logic            err;
		logic            closed;
		logic [3:0][7:0] seq;
		logic [20:0]     cp;
		int              nb;
		int              dv;
		int              i;
		dec_result_t     r;
		err = 1'b0;
		closed = 1'b0;
		seq = '0;
		nb = 0;
		case (dec_phase)
			PH_IDLE: begin
				if (b == CH_QUOTE) dec_phase = PH_BODY;
				else err = 1'b1;
			end
			PH_BODY: begin
				if (b == CH_QUOTE) closed = 1'b1;
				else if (b == CH_BSLASH) dec_phase = PH_ESC;
				else if (b < CH_SPACE) err = 1'b1;
				else begin
					seq[0] = b;
					nb = 1;
				end
			end
			PH_ESC: begin
				dec_phase = PH_BODY;
				nb = 1;
				case (b)
					CH_QUOTE, CH_BSLASH, CH_SLASH: seq[0] = b;
					CH_B: seq[0] = CTL_BS;
					CH_F: seq[0] = CTL_FF;
					CH_N: seq[0] = CTL_LF;
					CH_R: seq[0] = CTL_CR;
					CH_T: seq[0] = CTL_TAB;
					CH_U: begin
						nb = 0;
						dec_phase = PH_HEX1;
						hex_acc = '0;
						hex_cnt = '0;
					end
					default: begin
						nb = 0;
						err = 1'b1;
					end
				endcase
			end
			PH_HEX1, PH_HEX2: begin
				dv = hex_val(b);
				if (dv < 0) err = 1'b1;
				else begin
					hex_acc = {hex_acc[11:0], dv[3:0]};
					if (hex_cnt == 2'd3) begin
						hex_cnt = 2'd0;
						if (dec_phase == PH_HEX2) begin
							if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) err = 1'b1;
							else begin
								cp = 21'h10000 + {hi_half, 10'b0} + (hex_acc - 16'hDC00);
								nb = utf8_encode(cp, seq);
								dec_phase = PH_BODY;
							end
						end else if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
							hi_half = hex_acc[9:0];
							dec_phase = PH_WANTBS;
						end else begin
							nb = utf8_encode({5'b0, hex_acc}, seq);
							dec_phase = PH_BODY;
						end
					end else hex_cnt = hex_cnt + 2'd1;
				end
			end
			PH_WANTBS: begin
				if (b == CH_BSLASH) dec_phase = PH_WANTU;
				else err = 1'b1;
			end
			PH_WANTU: begin
				if (b == CH_U) begin
					dec_phase = PH_HEX2;
					hex_acc = '0;
					hex_cnt = '0;
				end else err = 1'b1;
			end
			default: dec_phase = PH_DRAIN;
		endcase

		// end of input anywhere but on the closing quote or while draining
		if (eoi && !err && !closed && dec_phase != PH_DRAIN) err = 1'b1;

		if (err || closed) begin
			r.data = '0;
			r.kind = err ? KIND_ERROR : KIND_CLOSE;
			r.last = 1'b1;
			expected_out.push_back(r);
			dec_phase = eoi ? PH_IDLE : PH_DRAIN;
		end else begin
			for (i = 0; i < nb; i++) begin
				r.data = seq[i];
				r.kind = KIND_BYTE;
				r.last = (i == nb - 1);
				expected_out.push_back(r);
			end
			if (eoi) dec_phase = PH_IDLE;
		end
	endtask

	// ---------------- stimulus helpers ----------------

	task automatic put_byte(input logic [7:0] b);
		src_byte_t s;
		s.data = b;
		s.eoi = 1'b0;
		src_bytes.push_back(s);
		bytes_queued++;
	endtask

	task automatic put_str(input string str);
		int i;
		for (i = 0; i < str.len(); i++) put_byte(str[i]);
	endtask

	task automatic mark_end();
		src_bytes[$].eoi = 1'b1;
		strings_queued++;
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) return DIG_0 + nib;
		return ($urandom_range(1) ? LOW_A : UP_A) + (nib - 4'd10);
	endfunction

	task automatic put_u(input logic [15:0] cp);
		int i;
		put_byte(CH_BSLASH);
		put_byte(CH_U);
		for (i = 3; i >= 0; i--) put_byte(hex_char(cp[i*4 +: 4]));
	endtask

	function automatic bit is_esc_letter(input logic [7:0] b);
		return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == CH_B || b == CH_F
			|| b == CH_N || b == CH_R || b == CH_T || b == CH_U;
	endfunction

	function automatic logic [7:0] rand_plain();
		logic [7:0] b;
		do b = 8'($urandom_range(8'h20, 8'hFF));
		while (b == CH_QUOTE || b == CH_BSLASH);
		return b;
	endfunction

	function automatic logic [15:0] rand_bmp();
		case ($urandom_range(3))
			0: return 16'($urandom_range(16'h0000, 16'h007F));
			1: return 16'($urandom_range(16'h0080, 16'h07FF));
			2: return 16'($urandom_range(16'h0800, 16'hD7FF));
			default: return 16'($urandom_range(16'hE000, 16'hFFFF));
		endcase
	endfunction

	task automatic put_simple_escape();
		logic [7:0] letters[8];
		letters = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};
		put_byte(CH_BSLASH);
		put_byte(letters[$urandom_range(7)]);
	endtask

	task automatic put_broken_escape();
		logic [7:0] b;
		int         i;
		int         good;
		put_byte(CH_BSLASH);
		case ($urandom_range(4))
			0: begin
				do b = 8'($urandom);
				while (is_esc_letter(b));
				put_byte(b);
			end
			1: begin
				// zero to three good hex digits, then a non-hex byte
				put_byte(CH_U);
				good = $urandom_range(3);
				for (i = 0; i < good; i++) put_byte(hex_char(4'($urandom)));
				do b = 8'($urandom);
				while (hex_val(b) >= 0);
				put_byte(b);
			end
			2: begin
				// high surrogate followed by something other than a backslash
				put_byte(CH_U);
				for (i = 3; i >= 0; i--) put_byte(hex_char(4'($urandom_range(16'hD800, 16'hDBFF) >> (i*4))));
				do b = 8'($urandom);
				while (b == CH_BSLASH);
				put_byte(b);
			end
			3: begin
				// high surrogate, backslash, not a u
				put_byte(CH_U);
				for (i = 3; i >= 0; i--) put_byte(hex_char(4'($urandom_range(16'hD800, 16'hDBFF) >> (i*4))));
				put_byte(CH_BSLASH);
				do b = 8'($urandom);
				while (b == CH_U);
				put_byte(b);
			end
			default: begin
				// high surrogate whose partner is not a low surrogate
				put_byte(CH_U);
				for (i = 3; i >= 0; i--) put_byte(hex_char(4'($urandom_range(16'hD800, 16'hDBFF) >> (i*4))));
				if ($urandom_range(1)) put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
				else put_u(rand_bmp());
			end
		endcase
	endtask

	// One random literal: mostly well formed, with some broken escapes and noise.
	task automatic gen_string();
		int n_tok;
		int pick;
		int n_tail;
		if ($urandom_range(99) < 4) begin
			put_byte(8'($urandom_range(8'h23, 8'hFF)));
		end else put_byte(CH_QUOTE);
		n_tok = $urandom_range(7);
		repeat (n_tok) begin
			pick = $urandom_range(99);
			if (pick < 40) put_byte(rand_plain());
			else if (pick < 56) put_simple_escape();
			else if (pick < 72) put_u(rand_bmp());
			else if (pick < 81) begin
				put_u(16'($urandom_range(16'hD800, 16'hDBFF)));
				put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
			end else if (pick < 85) put_u(16'($urandom_range(16'hDC00, 16'hDFFF)));
			else if (pick < 88) put_byte(8'($urandom_range(8'h1F)));
			else put_broken_escape();
		end
		pick = $urandom_range(99);
		if (pick < 80) put_byte(CH_QUOTE);
		else if (pick < 92) begin
			// closed early, then bytes that must be ignored
			put_byte(CH_QUOTE);
			n_tail = $urandom_range(1, 3);
			repeat (n_tail) put_byte(8'($urandom));
		end
		mark_end();
	endtask

	task automatic directed_strings();
		// pass-through extremes
		put_byte(CH_QUOTE);
		put_byte(8'h20); put_byte(8'h7E); put_byte(8'h7F); put_byte(8'h80); put_byte(8'hFF);
		put_byte(CH_QUOTE); mark_end();
		// all simple escapes
		put_byte(CH_QUOTE);
		put_byte(CH_BSLASH); put_byte(CH_QUOTE);
		put_byte(CH_BSLASH); put_byte(CH_BSLASH);
		put_byte(CH_BSLASH); put_byte(CH_SLASH);
		put_byte(CH_BSLASH); put_byte(CH_B);
		put_byte(CH_BSLASH); put_byte(CH_F);
		put_byte(CH_BSLASH); put_byte(CH_N);
		put_byte(CH_BSLASH); put_byte(CH_R);
		put_byte(CH_BSLASH); put_byte(CH_T);
		put_byte(CH_QUOTE); mark_end();
		// \u boundaries for 1, 2 and 3 byte encodings
		put_byte(CH_QUOTE);
		put_u(16'h0000); put_u(16'h007F); put_u(16'h0080); put_u(16'h07FF);
		put_u(16'h0800); put_u(16'hD7FF); put_u(16'hE000); put_u(16'hFFFF);
		put_byte(CH_QUOTE); mark_end();
		// surrogate pairs at both ends, lone low surrogates
		put_byte(CH_QUOTE);
		put_u(16'hD800); put_u(16'hDC00);
		put_u(16'hDBFF); put_u(16'hDFFF);
		put_u(16'hDC00); put_u(16'hDFFF);
		put_byte(CH_QUOTE); mark_end();
		// empty string
		put_byte(CH_QUOTE); put_byte(CH_QUOTE); mark_end();
		// first byte not a quote, rest ignored
		put_str("x1"); mark_end();
		// bad escape letter, then ignored bytes
		put_byte(CH_QUOTE); put_byte(CH_BSLASH); put_str("qzz"); mark_end();
		// non-hex digit, end on the failing byte
		put_byte(CH_QUOTE); put_byte(CH_BSLASH); put_byte(CH_U); put_str("12g"); mark_end();
		// high surrogate without backslash
		put_byte(CH_QUOTE); put_u(16'hD800); put_str("x"); put_byte(CH_QUOTE); mark_end();
		// high surrogate, backslash, not u
		put_byte(CH_QUOTE); put_u(16'hD800); put_byte(CH_BSLASH); put_byte(CH_N); mark_end();
		// partner below and above the low range
		put_byte(CH_QUOTE); put_u(16'hDBFF); put_u(16'hDBFF); put_byte(CH_QUOTE); mark_end();
		put_byte(CH_QUOTE); put_u(16'hD800); put_u(16'hE000); put_byte(CH_QUOTE); mark_end();
		// raw control bytes
		put_byte(CH_QUOTE); put_str("a"); put_byte(8'h1F); put_byte(CH_QUOTE); mark_end();
		put_byte(CH_QUOTE); put_byte(8'h00); mark_end();
		// unterminated: plain byte, backslash, last hex digit
		put_byte(CH_QUOTE); put_str("ab"); mark_end();
		put_byte(CH_QUOTE); put_byte(CH_BSLASH); mark_end();
		put_byte(CH_QUOTE); put_u(16'h00E9); mark_end();
		// closed early, trailing bytes ignored
		put_byte(CH_QUOTE); put_str("a"); put_byte(CH_QUOTE); put_str("xyz"); mark_end();
	endtask

	// ---------------- driver ----------------

	always @(posedge clk or negedge arst_n) begin
		src_byte_t s;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				unescape_byte(s_tdata, s_tlast);
				bytes_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (src_bytes.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
					s = src_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= s.data;
					s_tlast <= s.eoi;
				end else s_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- receiver and checker ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_go && hold_cnt < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
		end else m_tready <= ($urandom_range(99) >= rcv_idle_pct);
	end

	always @(posedge clk) begin
		dec_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (m_tuser == KIND_CLOSE) closes_seen++;
			if (m_tuser == KIND_ERROR) errors_seen++;
			if (expected_out.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result data=%02h kind=%0d last=%0b",
					$time, m_tdata, m_tuser, m_tlast);
			end else begin
				e = expected_out.pop_front();
				if (m_tdata !== e.data) begin
					fail_count++;
					$display("%0t: out_byte expected %02h actual %02h", $time, e.data, m_tdata);
				end
				if (m_tuser !== e.kind) begin
					fail_count++;
					$display("%0t: out_kind expected %0d actual %0d", $time, e.kind, m_tuser);
				end
				if (m_tlast !== e.last) begin
					fail_count++;
					$display("%0t: run_last expected %0b actual %0b", $time, e.last, m_tlast);
				end
			end
		end
	end

	// no request moving on either side for too long means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no request accepted for %0d cycles", $time, idle_cycles);
				$display("Test completed with failures");
				$finish;
			end else idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int start;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// slow receiver
		directed_strings();
		start = bytes_queued;
		while (bytes_queued - start < SECTION_BYTES) gen_string();
		while (src_bytes.size() > 0) @(posedge clk);

		// slow sender
		snd_idle_pct = 80;
		rcv_idle_pct = 19;
		start = bytes_queued;
		while (bytes_queued - start < SECTION_BYTES) gen_string();
		while (src_bytes.size() > 0) @(posedge clk);

		// full rate, opening with a long output stall so the input backs up
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		start = bytes_queued;
		while (bytes_queued - start < SECTION_BYTES) gen_string();
		hold_go = 1'b1;
		while (src_bytes.size() > 0 || s_tvalid) @(posedge clk);
		while (expected_out.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d source bytes in %0d literals; checked %0d results",
			bytes_sent, strings_queued, results_seen);
		$display("(%0d closes, %0d errors), %0d mismatches", closes_seen, errors_seen, fail_count);
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
